>>> src/decimal_escape_unescaper_macros.svh
// Assertion macros for the decimal escape unescaper.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef DECIMAL_ESCAPE_UNESCAPER_MACROS_SVH
`define DECIMAL_ESCAPE_UNESCAPER_MACROS_SVH

// cond must hold at every edge out of reset
`define DEU_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define DEU_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> src/deu_pkg.sv
// Shared types, character codes and helpers for the decimal escape unescaper.
// No dependencies.
`default_nettype none

package deu_pkg;

	localparam int unsigned RES_MAX = 3;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_TWO       = 8'h32;
	localparam logic [7:0] CH_FIVE      = 8'h35;

	typedef enum logic [1:0] {
		ST_PLAIN,
		ST_ESC,
		ST_D1,
		ST_D2
	} esc_stage_t;

	typedef struct packed {
		esc_stage_t stage;
		logic [1:0] d1;
		logic [2:0] d2;
	} dec_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       error_flag;
		logic       last_result;
	} res_t;

	typedef struct packed {
		res_t [RES_MAX-1:0] items;
		logic [1:0]         count;
	} res_list_t;

	function automatic res_t mk_res(logic [7:0] b, logic v, logic e);
		res_t r;
		r.out_byte    = b;
		r.byte_valid  = v;
		r.error_flag  = e;
		r.last_result = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] digit_char(logic [2:0] d);
		return CH_ZERO | {5'd0, d};
	endfunction

endpackage

`default_nettype wire

>>> src/deu_decode.sv
// Single-pass decode of one escaped character: next escape state and up to three results.
// Depends on deu_pkg.
`default_nettype none

module deu_decode (
	input  deu_pkg::dec_state_t cur,
	input  logic [7:0]          in_char,
	input  logic                end_of_string,
	input  logic                strict_mode,
	output deu_pkg::dec_state_t nxt,
	output deu_pkg::res_list_t  res
);
	import deu_pkg::*;

	logic       is_d02;
	logic       is_d05;
	logic [7:0] dec_val;
	logic [1:0] n;
	res_list_t  rl;
	dec_state_t st;

	assign is_d02 = (in_char >= CH_ZERO) && (in_char <= CH_TWO);
	assign is_d05 = (in_char >= CH_ZERO) && (in_char <= CH_FIVE);

	// max 2*100 + 5*10 + 5 = 255
	assign dec_val = ({6'd0, cur.d1} * 8'd100) + ({5'd0, cur.d2} * 8'd10)
		+ {5'd0, in_char[2:0]};

	always_comb begin
		rl = '0;
		n  = 2'd0;
		st = cur;
		case (cur.stage)
			ST_PLAIN: begin
				if (in_char == CH_BACKSLASH) begin
					st.stage = ST_ESC;
				end else begin
					rl.items[n] = mk_res(in_char, 1'b1, 1'b0);
					n = n + 2'd1;
				end
			end
			ST_ESC: begin
				if (is_d02) begin
					st.d1    = in_char[1:0];
					st.stage = ST_D1;
				end else begin
					st.stage = ST_PLAIN;
					rl.items[n] = mk_res(in_char, 1'b1, 1'b0);
					n = n + 2'd1;
				end
			end
			ST_D1: begin
				if (is_d05) begin
					st.d2    = in_char[2:0];
					st.stage = ST_D2;
				end else begin
					st.stage = ST_PLAIN;
					rl.items[n] = mk_res(digit_char({1'b0, cur.d1}), 1'b1, 1'b0);
					n = n + 2'd1;
					// failing char restarts in plain state
					if (in_char == CH_BACKSLASH) begin
						st.stage = ST_ESC;
					end else begin
						rl.items[n] = mk_res(in_char, 1'b1, 1'b0);
						n = n + 2'd1;
					end
				end
			end
			ST_D2: begin
				st.stage = ST_PLAIN;
				if (is_d05) begin
					rl.items[n] = mk_res(dec_val, 1'b1, 1'b0);
					n = n + 2'd1;
				end else begin
					rl.items[n] = mk_res(digit_char({1'b0, cur.d1}), 1'b1, 1'b0);
					n = n + 2'd1;
					rl.items[n] = mk_res(digit_char(cur.d2), 1'b1, 1'b0);
					n = n + 2'd1;
					if (in_char == CH_BACKSLASH) begin
						st.stage = ST_ESC;
					end else begin
						rl.items[n] = mk_res(in_char, 1'b1, 1'b0);
						n = n + 2'd1;
					end
				end
			end
			default: begin
				st.stage = ST_PLAIN;
			end
		endcase

		if (end_of_string) begin
			case (st.stage)
				ST_D1: begin
					rl.items[n] = mk_res(digit_char({1'b0, st.d1}), 1'b1, 1'b0);
					n = n + 2'd1;
				end
				ST_D2: begin
					rl.items[n] = mk_res(digit_char({1'b0, st.d1}), 1'b1, 1'b0);
					n = n + 2'd1;
					rl.items[n] = mk_res(digit_char(st.d2), 1'b1, 1'b0);
					n = n + 2'd1;
				end
				ST_ESC: begin
					// trailing backslash
					if (strict_mode) begin
						rl.items[n] = mk_res(8'd0, 1'b0, 1'b1);
						n = n + 2'd1;
					end
				end
				default: begin
				end
			endcase
			if (n == 2'd0) begin
				rl.items[n] = mk_res(8'd0, 1'b0, 1'b0);
				n = 2'd1;
			end
			rl.items[n - 2'd1].last_result = 1'b1;
			st = '0;
		end
		rl.count = n;
	end

	assign nxt = st;
	assign res = rl;

endmodule

`default_nettype wire

>>> src/decimal_escape_unescaper.sv
// Top level of the decimal escape unescaper: input register, decode, result buffer.
// Depends on deu_pkg, deu_decode and decimal_escape_unescaper_macros.svh.
//
//  port group  dir  payload
//  s_*         in   tdata = in_char, tlast = end_of_string
//  m_*         out  tdata = out_byte, tuser = {error_flag, byte_valid}, tlast = last_result
//  cfg_*       in   strict_mode, written when cfg_we is high
//
// A request enters the input register, is decoded in one pass and lands in a
// three-entry result buffer that drains one result per cycle while m_tready is high.
// Throughput is one request per cycle while m_tready is high and each yields at most one
// result; a request with more results holds the input until the buffer drains.
// Requests pass the input register and the result buffer. Reset clears all escape state.
`default_nettype none

`include "decimal_escape_unescaper_macros.svh"

module decimal_escape_unescaper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [0] byte_valid, [1] error_flag
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);
	import deu_pkg::*;

	logic                 strict_q;
	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 eos_s1;
	dec_state_t           state_q;
	dec_state_t           state_nxt;
	res_list_t            dec_res;
	res_t [RES_MAX-1:0]   buf_q;
	logic [1:0]           cnt_q;
	logic                 buf_free;
	logic                 move_s1;
	logic                 pop;

	deu_decode u_decode (
		.cur           (state_q),
		.in_char       (char_s1),
		.end_of_string (eos_s1),
		.strict_mode   (strict_q),
		.nxt           (state_nxt),
		.res           (dec_res)
	);

	assign pop      = m_tvalid && m_tready;
	assign buf_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);
	assign move_s1  = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b0;
			valid_s1 <= 1'b0;
			state_q  <= '0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				strict_q <= cfg_wdata;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (move_s1) begin
				state_q <= state_nxt;
				cnt_q   <= dec_res.count;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
		if (move_s1) begin
			buf_q <= dec_res.items;
		end else if (pop) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = buf_q[0].out_byte;
	assign m_tuser  = {buf_q[0].error_flag, buf_q[0].byte_valid};
	assign m_tlast  = buf_q[0].last_result;

	`DEU_ASSERT(a_load_into_free, !(move_s1 && (dec_res.count != 2'd0)) || (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready), "results loaded over pending ones")
	`DEU_ASSERT(a_last_is_final, !(m_tvalid && m_tlast) || (cnt_q == 2'd1), "end marker not final in buffer")
	`DEU_ASSERT_NEXT(a_end_clears, move_s1 && eos_s1, state_q == '0, "escape state not cleared at end")

endmodule

`default_nettype wire
